// ===== hdl/mafd_pkg.sv =====
// Shared types, codes and constants of the mesh advertisement filter.
package mafd_pkg;

  // Default sizes, handed to the top level as parameter defaults
  localparam int unsigned TABLE_ENTRIES = 4;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Stream payload widths (fields packed from bit 0, padded to bytes)
  localparam int unsigned IN_TDATA_W  = 80;
  localparam int unsigned OUT_TDATA_W = 32;

  // Header constants
  localparam logic [15:0] COMPANY_TAG = 16'hFFFF;
  localparam logic [7:0]  KIND_FORM   = 8'h01;
  localparam logic [7:0]  KIND_MEAS   = 8'h04;
  localparam logic [4:0]  HDR_BYTES   = 5'd6;
  localparam logic [4:0]  FORM_BYTES  = 5'd7;
  localparam logic [4:0]  MEAS_BYTES  = 5'd17;

  typedef enum logic [1:0] {
    ROLE_IDLE  = 2'd0,
    ROLE_SINK  = 2'd1,
    ROLE_RELAY = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_DROP    = 3'd1,
    ACT_JOIN    = 3'd2,
    ACT_SINK    = 3'd3,
    ACT_DELIVER = 3'd4,
    ACT_FORWARD = 3'd5,
    ACT_FULL    = 3'd6
  } action_e;

  // Classified command handed from the front to the back
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_DROP  = 3'd1,
    CMD_PRESS = 3'd2,
    CMD_FORM  = 3'd3,
    CMD_MEAS  = 3'd4
  } cmd_e;

  typedef enum logic [0:0] {
    CFG_OWN_NODE = 1'b0,
    CFG_OWN_NET  = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [23:0] net;
    logic [7:0]  src;
    logic [15:0] cnt;
  } cmd_t;

endpackage

// ===== hdl/mesh_advert_filter_dedup.sv =====
// Top level of the mesh advertisement filter and duplicate suppressor.
//
// One result transaction leaves for every input transaction, in order.
// Throughput is one transaction per clock while the output is not stalled: the
// front classifies a header in the cycle it is accepted and pushes a command into
// a QueueDepth-entry queue; the back pops one command per cycle when the output
// register is empty or being drained, updates role, network id and the
// TableEntries-slot duplicate table in that single cycle (all slots are compared
// in parallel) and registers the result. A command passes the queue and then the
// output register before its result is offered. The queue and the output register
// let input and output stall independently; input tready drops only when the
// queue is full. Configuration writes are always taken (cfg_ready_o is high)
// and must only be issued while no transaction is in flight.
module mesh_advert_filter_dedup #(
  parameter int unsigned TableEntries = mafd_pkg::TABLE_ENTRIES,  // 1 to 64
  parameter int unsigned QueueDepth   = mafd_pkg::QUEUE_DEPTH     // 2 or more
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Config write: index 0 own_node (data[7:0]), index 1 own_net_addr (data[23:0])
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [0:0]                       cfg_addr_i,
  input  logic [23:0]                      cfg_data_i,
  // Input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // tdata from bit 0: pressed(1) payload_len(5) is_manuf(1) company_code(16)
  //   msg_kind(8) rx_net(24) src_node(8) seq_count(16), zero pad(1)
  input  logic [mafd_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // tuser: req_type(1)
  input  logic                             s_axis_tuser_i,
  // Output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // tdata from bit 0: action(3) role(2) net_out(24), zero pad(3)
  output logic [mafd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned CmdW = $bits(mafd_pkg::cmd_t);

  logic [7:0]     own_node_q, own_node_d;
  logic [23:0]    own_net_q, own_net_d;

  logic           q_push, q_ready, q_pop, q_valid;
  mafd_pkg::cmd_t push_cmd, pop_cmd;
  logic [CmdW-1:0] pop_bits;

  // Configuration registers: never stall the write channel
  assign cfg_ready_o = 1'b1;

  always_comb begin
    own_node_d = own_node_q;
    own_net_d  = own_net_q;
    if (cfg_valid_i) begin
      case (mafd_pkg::cfg_idx_e'(cfg_addr_i))
        mafd_pkg::CFG_OWN_NODE: own_node_d = cfg_data_i[7:0];
        mafd_pkg::CFG_OWN_NET:  own_net_d  = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_node_q <= '0;
      own_net_q  <= '0;
    end else begin
      own_node_q <= own_node_d;
      own_net_q  <= own_net_d;
    end
  end

  // Classify headers; own-source and length checks need no state
  mafd_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .own_node_i      (own_node_q),
    .q_ready_i       (q_ready),
    .q_push_o        (q_push),
    .q_cmd_o         (push_cmd)
  );

  // Decouple classification from execution
  mafd_fifo #(
    .Width (CmdW),
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (push_cmd),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (pop_bits)
  );

  assign pop_cmd = mafd_pkg::cmd_t'(pop_bits);

  // Execute commands against role and duplicate table, hold the result
  mafd_back #(
    .TableEntries (TableEntries)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_cmd_i         (pop_cmd),
    .q_pop_o         (q_pop),
    .own_net_addr_i  (own_net_q),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

endmodule

// ===== hdl/mafd_front.sv =====
// Front end: accepts stream transactions and classifies headers into commands.
module mafd_front (
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [mafd_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  input  logic                                s_axis_tuser_i,
  input  logic [7:0]                          own_node_i,
  input  logic                                q_ready_i,
  output logic                                q_push_o,
  output mafd_pkg::cmd_t                      q_cmd_o
);

  logic        pressed;
  logic [4:0]  payload_len;
  logic        is_manuf;
  logic [15:0] company_code;
  logic [7:0]  msg_kind;
  logic [23:0] rx_net;
  logic [7:0]  src_node;
  logic [15:0] seq_count;

  assign pressed      = s_axis_tdata_i[0];
  assign payload_len  = s_axis_tdata_i[5:1];
  assign is_manuf     = s_axis_tdata_i[6];
  assign company_code = s_axis_tdata_i[22:7];
  assign msg_kind     = s_axis_tdata_i[30:23];
  assign rx_net       = s_axis_tdata_i[54:31];
  assign src_node     = s_axis_tdata_i[62:55];
  assign seq_count    = s_axis_tdata_i[78:63];

  // Stateless checks here; everything that needs role or table goes to the back
  always_comb begin
    q_cmd_o.net = rx_net;
    q_cmd_o.src = src_node;
    q_cmd_o.cnt = seq_count;
    if (s_axis_tuser_i) begin
      q_cmd_o.cmd = pressed ? mafd_pkg::CMD_PRESS : mafd_pkg::CMD_NONE;
    end else if (!is_manuf || (payload_len < mafd_pkg::HDR_BYTES) ||
                 (company_code != mafd_pkg::COMPANY_TAG)) begin
      q_cmd_o.cmd = mafd_pkg::CMD_NONE;
    end else if (msg_kind == mafd_pkg::KIND_FORM) begin
      q_cmd_o.cmd = (payload_len < mafd_pkg::FORM_BYTES) ? mafd_pkg::CMD_DROP
                                                          : mafd_pkg::CMD_FORM;
    end else if (msg_kind == mafd_pkg::KIND_MEAS) begin
      q_cmd_o.cmd = ((payload_len < mafd_pkg::MEAS_BYTES) || (src_node == own_node_i))
                    ? mafd_pkg::CMD_DROP : mafd_pkg::CMD_MEAS;
    end else begin
      q_cmd_o.cmd = mafd_pkg::CMD_NONE;
    end
  end

  assign s_axis_tready_o = q_ready_i;
  assign q_push_o        = s_axis_tvalid_i & q_ready_i;

endmodule

// ===== hdl/mafd_fifo.sv =====
// Short command queue between the front and the back.
module mafd_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = mafd_pkg::QUEUE_DEPTH  // at least 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             ready_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] data_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign ready_o = (count_q != FullCnt);
  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/mafd_back.sv =====
// Back end: role, network id and duplicate table; produces the registered result.
module mafd_back #(
  parameter int unsigned TableEntries = mafd_pkg::TABLE_ENTRIES
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             q_valid_i,
  input  mafd_pkg::cmd_t                   q_cmd_i,
  output logic                             q_pop_o,
  input  logic [23:0]                      own_net_addr_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mafd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;

  mafd_pkg::role_e   role_q, role_d;
  logic [23:0]       net_q, net_d;
  logic              used_q [TableEntries];
  logic [7:0]        src_q  [TableEntries];
  logic [15:0]       cnt_q  [TableEntries];

  logic              out_valid_q;
  mafd_pkg::action_e out_act_q, act;
  mafd_pkg::role_e   out_role_q;
  logic [23:0]       out_net_q;

  logic              hit, free_any, tbl_wr;
  logic [IdxW-1:0]   hit_idx, free_idx, wr_idx;
  mafd_pkg::action_e accept_act;

  assign q_pop_o = q_valid_i & (~out_valid_q | m_axis_tready_i);

  // Lowest used slot with matching source, and lowest free slot
  always_comb begin
    hit      = 1'b0;
    hit_idx  = '0;
    free_any = 1'b0;
    free_idx = '0;
    for (int k = 0; k < TableEntries; k++) begin
      if (!hit && used_q[k] && (src_q[k] == q_cmd_i.src)) begin
        hit     = 1'b1;
        hit_idx = IdxW'(k);
      end
      if (!free_any && !used_q[k]) begin
        free_any = 1'b1;
        free_idx = IdxW'(k);
      end
    end
  end

  assign accept_act = (role_q == mafd_pkg::ROLE_SINK) ? mafd_pkg::ACT_DELIVER
                                                      : mafd_pkg::ACT_FORWARD;

  always_comb begin
    act    = mafd_pkg::ACT_NONE;
    role_d = role_q;
    net_d  = net_q;
    tbl_wr = 1'b0;
    wr_idx = free_idx;
    case (q_cmd_i.cmd)
      mafd_pkg::CMD_NONE: act = mafd_pkg::ACT_NONE;
      mafd_pkg::CMD_DROP: act = mafd_pkg::ACT_DROP;
      mafd_pkg::CMD_PRESS: begin
        if (role_q == mafd_pkg::ROLE_IDLE) begin
          act    = mafd_pkg::ACT_SINK;
          role_d = mafd_pkg::ROLE_SINK;
          net_d  = own_net_addr_i;
        end
      end
      mafd_pkg::CMD_FORM: begin
        if (role_q == mafd_pkg::ROLE_IDLE) begin
          act    = mafd_pkg::ACT_JOIN;
          role_d = mafd_pkg::ROLE_RELAY;
          net_d  = q_cmd_i.net;
        end else begin
          act = mafd_pkg::ACT_DROP;
        end
      end
      mafd_pkg::CMD_MEAS: begin
        if ((q_cmd_i.net != net_q) || (role_q == mafd_pkg::ROLE_IDLE)) begin
          act = mafd_pkg::ACT_DROP;
        end else if (hit) begin
          if (q_cmd_i.cnt > cnt_q[hit_idx]) begin
            act    = accept_act;
            tbl_wr = 1'b1;
            wr_idx = hit_idx;
          end else begin
            act = mafd_pkg::ACT_DROP;
          end
        end else if (free_any) begin
          act    = accept_act;
          tbl_wr = 1'b1;
        end else begin
          act = mafd_pkg::ACT_FULL;
        end
      end
      default: act = mafd_pkg::ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      role_q      <= mafd_pkg::ROLE_IDLE;
      net_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < TableEntries; k++) begin
        used_q[k] <= 1'b0;
      end
    end else begin
      if (q_pop_o) begin
        role_q      <= role_d;
        net_q       <= net_d;
        out_valid_q <= 1'b1;
        if (tbl_wr) begin
          used_q[wr_idx] <= 1'b1;
        end
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_act_q  <= act;
      out_role_q <= role_d;
      out_net_q  <= net_d;
      if (tbl_wr) begin
        src_q[wr_idx] <= q_cmd_i.src;
        cnt_q[wr_idx] <= q_cmd_i.cnt;
      end
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_net_q, out_role_q, out_act_q};

endmodule

// ===== hdl/mafd_checker.sv =====
// Port-level assertions for the mesh advertisement filter, bound to the top level.
module mafd_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             m_axis_tvalid_i,
  input logic                             m_axis_tready_i,
  input logic [mafd_pkg::OUT_TDATA_W-1:0] m_axis_tdata_i
);

  logic [2:0] act;
  logic [1:0] role;

  assign act  = m_axis_tdata_i[2:0];
  assign role = m_axis_tdata_i[4:3];

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("stalled result changed");

  a_sink_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (act == mafd_pkg::ACT_SINK || act == mafd_pkg::ACT_DELIVER)
    |-> role == mafd_pkg::ROLE_SINK)
    else $error("sink action without sink role");

  a_relay_role: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && (act == mafd_pkg::ACT_JOIN || act == mafd_pkg::ACT_FORWARD)
    |-> role == mafd_pkg::ROLE_RELAY)
    else $error("relay action without relay role");

  a_idle_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && role == mafd_pkg::ROLE_IDLE
    |-> act == mafd_pkg::ACT_NONE || act == mafd_pkg::ACT_DROP)
    else $error("idle node reported a table action");

endmodule

bind mesh_advert_filter_dedup mafd_checker u_mafd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
